>>> rtl/prr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_pkg
// Widths, register indexes and shared types of the reprojection residual block.
// ----------------------------------------------------------------------------
package prr_pkg;

   // port widths
   localparam int COORD_WIDTH = 21;
   localparam int PIXEL_WIDTH = 16;
   localparam int QUAT_LANE   = 16;
   localparam int VEC_LANE    = 21;
   localparam int QUAT_REG_W  = 4 * QUAT_LANE;
   localparam int VEC_REG_W   = 3 * VEC_LANE;
   localparam int CSR_DATA_W  = QUAT_REG_W;
   localparam int CSR_INDEX_W = 3;

   // datapath widths
   localparam int R_FRAC  = 14;
   localparam int QPROD_W = 2 * QUAT_LANE;
   localparam int R28_W   = 2 * QUAT_LANE + 3;
   localparam int ROT_W   = R28_W - R_FRAC;
   localparam int RP_W    = ROT_W + COORD_WIDTH;
   localparam int ACC_W   = RP_W + 2;
   localparam int PC_W    = ACC_W - R_FRAC;
   localparam int KP_W    = VEC_LANE + PC_W;
   localparam int H_W     = KP_W + 2;
   localparam int DIV_D_W = H_W - 1;
   localparam int DIV_N_W = H_W + 4;
   localparam int QUO_W   = PIXEL_WIDTH + 1;
   localparam int REM_W   = DIV_D_W + QUO_W;
   localparam int RES_W   = QUO_W + 2;

   localparam logic signed [R28_W-1:0] R_ONE  = R28_W'(1) << (2 * R_FRAC);
   localparam logic signed [R28_W-1:0] R_HALF = R28_W'(1) << (R_FRAC - 1);
   localparam logic signed [ACC_W-1:0] PC_HALF = ACC_W'(1) << (R_FRAC - 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROTATION_QUAT   = 3'd0,
      CSR_TRANSLATION_VEC = 3'd1,
      CSR_INTRINSIC_ROW0  = 3'd2,
      CSR_INTRINSIC_ROW1  = 3'd3,
      CSR_INTRINSIC_ROW2  = 3'd4
   } csr_index_type;

   // homogeneous projection handed from the transform to the divider
   typedef struct packed {
      logic signed [H_W-1:0]       h0;
      logic signed [H_W-1:0]       h1;
      logic signed [H_W-1:0]       h2;
      logic [PIXEL_WIDTH-1:0]      pixel_u;
      logic [PIXEL_WIDTH-1:0]      pixel_v;
   } proj_type;

endpackage

>>> rtl/prr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_req_if / prr_rsp_if
// Valid/ready channels for points in and residuals out.
// ----------------------------------------------------------------------------
interface prr_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [prr_pkg::COORD_WIDTH-1:0]  point_x;
   logic signed [prr_pkg::COORD_WIDTH-1:0]  point_y;
   logic signed [prr_pkg::COORD_WIDTH-1:0]  point_z;
   logic [prr_pkg::PIXEL_WIDTH-1:0]         pixel_u;
   logic [prr_pkg::PIXEL_WIDTH-1:0]         pixel_v;

   modport source (output valid, output point_x, output point_y, output point_z,
                   output pixel_u, output pixel_v, input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   input pixel_u, input pixel_v, output ready);
endinterface

interface prr_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [prr_pkg::PIXEL_WIDTH-1:0]  residual_u;
   logic signed [prr_pkg::PIXEL_WIDTH-1:0]  residual_v;
   logic                                    depth_invalid;
   logic                                    saturated;

   modport source (output valid, output residual_u, output residual_v,
                   output depth_invalid, output saturated, input ready);
   modport sink   (input valid, input residual_u, input residual_v,
                   input depth_invalid, input saturated, output ready);
endinterface

>>> rtl/prr_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_transform
// Six-stage pipeline: quaternion to rotation, rigid transform, intrinsic product.
// ----------------------------------------------------------------------------
module prr_transform (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [prr_pkg::QUAT_REG_W-1:0]     rotation_quat,
   input  logic [prr_pkg::VEC_REG_W-1:0]      translation_vec,
   input  logic [prr_pkg::VEC_REG_W-1:0]      intrinsic_row0,
   input  logic [prr_pkg::VEC_REG_W-1:0]      intrinsic_row1,
   input  logic [prr_pkg::VEC_REG_W-1:0]      intrinsic_row2,
   prr_req_if.sink                            req_ch,
   output logic                               out_valid,
   input  logic                               out_ready,
   output prr_pkg::proj_type                  proj
);
   localparam int NST = 6;

   logic [NST-1:0] v_ff, v_in;
   logic [NST:0]   rdy;

   logic signed [prr_pkg::QUAT_LANE-1:0]   qx, qy, qz, qw;
   logic signed [prr_pkg::QPROD_W-1:0]     qxx_ff, qyy_ff, qzz_ff, qxy_ff, qxz_ff;
   logic signed [prr_pkg::QPROD_W-1:0]     qyz_ff, qxw_ff, qyw_ff, qzw_ff;
   logic signed [prr_pkg::COORD_WIDTH-1:0] p1_ff [3];
   logic signed [prr_pkg::COORD_WIDTH-1:0] p2_ff [3];
   logic signed [prr_pkg::R28_W-1:0]       r28 [9];
   logic signed [prr_pkg::R28_W-1:0]       rsum [9];
   logic signed [prr_pkg::ROT_W-1:0]       r_ff [9];
   logic signed [prr_pkg::RP_W-1:0]        rp_ff [9];
   logic signed [prr_pkg::ACC_W-1:0]       acc [3];
   logic signed [prr_pkg::VEC_LANE-1:0]    tvec [3];
   logic signed [prr_pkg::PC_W-1:0]        pc_ff [3];
   logic [prr_pkg::VEC_REG_W-1:0]          krow [3];
   logic signed [prr_pkg::VEC_LANE-1:0]    kmat [9];
   logic signed [prr_pkg::KP_W-1:0]        kp_ff [9];
   logic signed [prr_pkg::H_W-1:0]         h_ff [3];
   logic [prr_pkg::PIXEL_WIDTH-1:0]        pu_ff [NST];
   logic [prr_pkg::PIXEL_WIDTH-1:0]        pv_ff [NST];

   // a stage loads when it is empty or its successor moves
   assign rdy[NST] = out_ready;
   for (genvar s = 0; s < NST; s++) begin : g_rdy
      assign rdy[s] = !v_ff[s] || rdy[s+1];
   end

   always_comb begin
      v_in = v_ff;
      if (rdy[0]) begin
         v_in[0] = req_ch.valid;
      end
      for (int s = 1; s < NST; s++) begin
         if (rdy[s]) begin
            v_in[s] = v_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ch.ready = rdy[0];
   assign out_valid    = v_ff[NST-1];

   assign qx = $signed(rotation_quat[0*prr_pkg::QUAT_LANE +: prr_pkg::QUAT_LANE]);
   assign qy = $signed(rotation_quat[1*prr_pkg::QUAT_LANE +: prr_pkg::QUAT_LANE]);
   assign qz = $signed(rotation_quat[2*prr_pkg::QUAT_LANE +: prr_pkg::QUAT_LANE]);
   assign qw = $signed(rotation_quat[3*prr_pkg::QUAT_LANE +: prr_pkg::QUAT_LANE]);

   assign krow[0] = intrinsic_row0;
   assign krow[1] = intrinsic_row1;
   assign krow[2] = intrinsic_row2;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tvec[i] = $signed(translation_vec[i*prr_pkg::VEC_LANE +: prr_pkg::VEC_LANE]);
         for (int j = 0; j < 3; j++) begin
            kmat[i*3+j] = $signed(krow[i][j*prr_pkg::VEC_LANE +: prr_pkg::VEC_LANE]);
         end
      end
   end

   // rotation entries at scale 2^28, then rounded to 2^14
   always_comb begin
      r28[0] = prr_pkg::R_ONE - ((prr_pkg::R28_W'(qyy_ff) + prr_pkg::R28_W'(qzz_ff)) <<< 1);
      r28[1] = (prr_pkg::R28_W'(qxy_ff) - prr_pkg::R28_W'(qzw_ff)) <<< 1;
      r28[2] = (prr_pkg::R28_W'(qxz_ff) + prr_pkg::R28_W'(qyw_ff)) <<< 1;
      r28[3] = (prr_pkg::R28_W'(qxy_ff) + prr_pkg::R28_W'(qzw_ff)) <<< 1;
      r28[4] = prr_pkg::R_ONE - ((prr_pkg::R28_W'(qxx_ff) + prr_pkg::R28_W'(qzz_ff)) <<< 1);
      r28[5] = (prr_pkg::R28_W'(qyz_ff) - prr_pkg::R28_W'(qxw_ff)) <<< 1;
      r28[6] = (prr_pkg::R28_W'(qxz_ff) - prr_pkg::R28_W'(qyw_ff)) <<< 1;
      r28[7] = (prr_pkg::R28_W'(qyz_ff) + prr_pkg::R28_W'(qxw_ff)) <<< 1;
      r28[8] = prr_pkg::R_ONE - ((prr_pkg::R28_W'(qxx_ff) + prr_pkg::R28_W'(qyy_ff)) <<< 1);
      for (int i = 0; i < 9; i++) begin
         rsum[i] = r28[i] + prr_pkg::R_HALF;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = (prr_pkg::ACC_W'(tvec[i]) <<< prr_pkg::R_FRAC)
                  + prr_pkg::ACC_W'(rp_ff[i*3]) + prr_pkg::ACC_W'(rp_ff[i*3+1])
                  + prr_pkg::ACC_W'(rp_ff[i*3+2]) + prr_pkg::PC_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         qxx_ff   <= qx * qx;
         qyy_ff   <= qy * qy;
         qzz_ff   <= qz * qz;
         qxy_ff   <= qx * qy;
         qxz_ff   <= qx * qz;
         qyz_ff   <= qy * qz;
         qxw_ff   <= qx * qw;
         qyw_ff   <= qy * qw;
         qzw_ff   <= qz * qw;
         p1_ff[0] <= req_ch.point_x;
         p1_ff[1] <= req_ch.point_y;
         p1_ff[2] <= req_ch.point_z;
         pu_ff[0] <= req_ch.pixel_u;
         pv_ff[0] <= req_ch.pixel_v;
      end
      if (rdy[1]) begin
         for (int i = 0; i < 9; i++) begin
            r_ff[i] <= $signed(rsum[i][prr_pkg::R28_W-1:prr_pkg::R_FRAC]);
         end
         p2_ff <= p1_ff;
      end
      if (rdy[2]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               rp_ff[i*3+j] <= r_ff[i*3+j] * p2_ff[j];
            end
         end
      end
      if (rdy[3]) begin
         for (int i = 0; i < 3; i++) begin
            pc_ff[i] <= $signed(acc[i][prr_pkg::ACC_W-1:prr_pkg::R_FRAC]);
         end
      end
      if (rdy[4]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               kp_ff[i*3+j] <= kmat[i*3+j] * pc_ff[j];
            end
         end
      end
      if (rdy[5]) begin
         for (int i = 0; i < 3; i++) begin
            h_ff[i] <= prr_pkg::H_W'(kp_ff[i*3]) + prr_pkg::H_W'(kp_ff[i*3+1])
                       + prr_pkg::H_W'(kp_ff[i*3+2]);
         end
      end
      for (int s = 1; s < NST; s++) begin
         if (rdy[s]) begin
            pu_ff[s] <= pu_ff[s-1];
            pv_ff[s] <= pv_ff[s-1];
         end
      end
   end

   assign proj.h0      = h_ff[0];
   assign proj.h1      = h_ff[1];
   assign proj.h2      = h_ff[2];
   assign proj.pixel_u = pu_ff[NST-1];
   assign proj.pixel_v = pv_ff[NST-1];

   // h0 and h2 of a held projection must not change under a stall
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(h_ff[2]) && $stable(h_ff[0])))
      else $error("projection changed while stalled");

endmodule

>>> rtl/prr_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_divider
// Pipelined restoring divide of h0, h1 by h2, one quotient bit per stage,
// then pixel subtraction and clamping into the output register.
// ----------------------------------------------------------------------------
module prr_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  prr_pkg::proj_type  proj,
   prr_rsp_if.source          rsp_ch
);
   localparam int QW  = prr_pkg::QUO_W;
   localparam int NST = QW + 3;
   localparam int PW  = prr_pkg::PIXEL_WIDTH;
   localparam logic signed [prr_pkg::RES_W-1:0] RES_MAX = prr_pkg::RES_W'((1 << (PW - 1)) - 1);
   localparam logic signed [prr_pkg::RES_W-1:0] RES_MIN = -prr_pkg::RES_W'(1 << (PW - 1));

   typedef struct packed {
      logic                          inv;
      logic                          neg_u;
      logic                          neg_v;
      logic [prr_pkg::DIV_N_W-1:0]   num_u;
      logic [prr_pkg::DIV_N_W-1:0]   num_v;
      logic [prr_pkg::DIV_D_W-1:0]   den;
      logic [PW-1:0]                 pix_u;
      logic [PW-1:0]                 pix_v;
   } prep_type;

   typedef struct packed {
      logic                          inv;
      logic                          neg_u;
      logic                          neg_v;
      logic                          ovf_u;
      logic                          ovf_v;
      logic [prr_pkg::REM_W-1:0]     rem_u;
      logic [prr_pkg::REM_W-1:0]     rem_v;
      logic [QW-1:0]                 quo_u;
      logic [QW-1:0]                 quo_v;
      logic [prr_pkg::DIV_D_W-1:0]   den;
      logic [PW-1:0]                 pix_u;
      logic [PW-1:0]                 pix_v;
   } div_stage_type;

   logic [NST-1:0] v_ff, v_in;
   logic [NST:0]   rdy;

   prep_type       prep_in, prep_ff;
   div_stage_type  st_in;
   div_stage_type  st_ff [QW+1];

   logic [prr_pkg::H_W-1:0]   abs_u, abs_v;
   logic [prr_pkg::REM_W-1:0] den_top;

   logic signed [prr_pkg::RES_W-1:0] qs_u, qs_v, rs_u, rs_v;
   logic signed [PW-1:0] res_u_in, res_v_in, res_u_ff, res_v_ff;
   logic sat_in, sat_ff, inv_ff;

   assign rdy[NST] = rsp_ch.ready;
   for (genvar s = 0; s < NST; s++) begin : g_rdy
      assign rdy[s] = !v_ff[s] || rdy[s+1];
   end

   always_comb begin
      v_in = v_ff;
      if (rdy[0]) begin
         v_in[0] = in_valid;
      end
      for (int s = 1; s < NST; s++) begin
         if (rdy[s]) begin
            v_in[s] = v_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign in_ready = rdy[0];

   // magnitudes, rounding bias folded into the dividend
   always_comb begin
      abs_u = proj.h0[prr_pkg::H_W-1] ? prr_pkg::H_W'(-proj.h0) : proj.h0;
      abs_v = proj.h1[prr_pkg::H_W-1] ? prr_pkg::H_W'(-proj.h1) : proj.h1;
      prep_in.inv   = proj.h2[prr_pkg::H_W-1] || (proj.h2 == '0);
      prep_in.neg_u = proj.h0[prr_pkg::H_W-1];
      prep_in.neg_v = proj.h1[prr_pkg::H_W-1];
      prep_in.den   = proj.h2[prr_pkg::DIV_D_W-1:0];
      prep_in.num_u = {abs_u, 4'b0000} + prr_pkg::DIV_N_W'(prep_in.den >> 1);
      prep_in.num_v = {abs_v, 4'b0000} + prr_pkg::DIV_N_W'(prep_in.den >> 1);
      prep_in.pix_u = proj.pixel_u;
      prep_in.pix_v = proj.pixel_v;
   end

   // quotients at or beyond the cap always saturate, so only the flag is kept
   always_comb begin
      den_top     = {prep_ff.den, {QW{1'b0}}};
      st_in.inv   = prep_ff.inv;
      st_in.neg_u = prep_ff.neg_u;
      st_in.neg_v = prep_ff.neg_v;
      st_in.rem_u = prr_pkg::REM_W'(prep_ff.num_u);
      st_in.rem_v = prr_pkg::REM_W'(prep_ff.num_v);
      st_in.ovf_u = st_in.rem_u >= den_top;
      st_in.ovf_v = st_in.rem_v >= den_top;
      st_in.quo_u = '0;
      st_in.quo_v = '0;
      st_in.den   = prep_ff.den;
      st_in.pix_u = prep_ff.pix_u;
      st_in.pix_v = prep_ff.pix_v;
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         prep_ff <= prep_in;
      end
      if (rdy[1]) begin
         st_ff[0] <= st_in;
      end
   end

   for (genvar j = 1; j <= QW; j++) begin : g_step
      localparam int K = QW - j;
      logic [prr_pkg::REM_W-1:0] dsh;
      logic ge_u, ge_v;
      div_stage_type nxt;

      always_comb begin
         nxt  = st_ff[j-1];
         dsh  = prr_pkg::REM_W'(st_ff[j-1].den) << K;
         ge_u = st_ff[j-1].rem_u >= dsh;
         ge_v = st_ff[j-1].rem_v >= dsh;
         nxt.quo_u[K] = st_ff[j-1].ovf_u || ge_u;
         nxt.quo_v[K] = st_ff[j-1].ovf_v || ge_v;
         if (ge_u && !st_ff[j-1].ovf_u) begin
            nxt.rem_u = st_ff[j-1].rem_u - dsh;
         end
         if (ge_v && !st_ff[j-1].ovf_v) begin
            nxt.rem_v = st_ff[j-1].rem_v - dsh;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[j+1]) begin
            st_ff[j] <= nxt;
         end
      end
   end

   // sign, pixel subtraction and clamp; an invalid depth zeroes both residuals
   always_comb begin
      qs_u = st_ff[QW].neg_u ? -$signed({2'b00, st_ff[QW].quo_u})
                             : $signed({2'b00, st_ff[QW].quo_u});
      qs_v = st_ff[QW].neg_v ? -$signed({2'b00, st_ff[QW].quo_v})
                             : $signed({2'b00, st_ff[QW].quo_v});
      rs_u = qs_u - $signed({3'b000, st_ff[QW].pix_u});
      rs_v = qs_v - $signed({3'b000, st_ff[QW].pix_v});
      sat_in   = 1'b0;
      res_u_in = $signed(rs_u[PW-1:0]);
      res_v_in = $signed(rs_v[PW-1:0]);
      if (rs_u > RES_MAX) begin
         res_u_in = $signed(RES_MAX[PW-1:0]);
         sat_in   = 1'b1;
      end else if (rs_u < RES_MIN) begin
         res_u_in = $signed(RES_MIN[PW-1:0]);
         sat_in   = 1'b1;
      end
      if (rs_v > RES_MAX) begin
         res_v_in = $signed(RES_MAX[PW-1:0]);
         sat_in   = 1'b1;
      end else if (rs_v < RES_MIN) begin
         res_v_in = $signed(RES_MIN[PW-1:0]);
         sat_in   = 1'b1;
      end
      if (st_ff[QW].inv) begin
         res_u_in = '0;
         res_v_in = '0;
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[NST-1]) begin
         res_u_ff <= res_u_in;
         res_v_ff <= res_v_in;
         sat_ff   <= sat_in;
         inv_ff   <= st_ff[QW].inv;
      end
   end

   assign rsp_ch.valid         = v_ff[NST-1];
   assign rsp_ch.residual_u    = res_u_ff;
   assign rsp_ch.residual_v    = res_v_ff;
   assign rsp_ch.depth_invalid = inv_ff;
   assign rsp_ch.saturated     = sat_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.depth_invalid) |->
         (rsp_ch.residual_u == '0 && rsp_ch.residual_v == '0 && !rsp_ch.saturated))
      else $error("invalid depth item carries residuals");

   assert property (@(posedge clock) disable iff (reset)
      (v_ff[QW+1] && !st_ff[QW].inv && !st_ff[QW].ovf_u) |->
         (st_ff[QW].rem_u < prr_pkg::REM_W'(st_ff[QW].den)))
      else $error("divider remainder not below divisor");

   assert property (@(posedge clock) disable iff (reset)
      (v_ff[0] && !prep_ff.inv) |-> (prep_ff.den != '0))
      else $error("zero divisor on a valid depth");

endmodule

>>> rtl/pinhole_reprojection_residual.sv
`timescale 1ns / 1ps
// throughput: one item per clock when not stalled; one quotient bit per pipeline stage
// a stall holds each occupied stage, empty stages still fill, so bubbles are squeezed out
// reset clears all stage valid bits and the configuration registers to zero
// ----------------------------------------------------------------------------
// pinhole_reprojection_residual
// Fixed-point pinhole reprojection residual of a lidar point against a pixel.
// ----------------------------------------------------------------------------
module pinhole_reprojection_residual (
   input  logic                                clock,
   input  logic                                reset,
   prr_req_if.sink                             req_ch,
   prr_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [prr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [prr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   logic [prr_pkg::QUAT_REG_W-1:0] rotation_quat_ff;
   logic [prr_pkg::VEC_REG_W-1:0]  translation_vec_ff;
   logic [prr_pkg::VEC_REG_W-1:0]  intrinsic_row0_ff;
   logic [prr_pkg::VEC_REG_W-1:0]  intrinsic_row1_ff;
   logic [prr_pkg::VEC_REG_W-1:0]  intrinsic_row2_ff;

   logic              proj_valid;
   logic              proj_ready;
   prr_pkg::proj_type proj;

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_quat_ff   <= '0;
         translation_vec_ff <= '0;
         intrinsic_row0_ff  <= '0;
         intrinsic_row1_ff  <= '0;
         intrinsic_row2_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            prr_pkg::CSR_ROTATION_QUAT: begin
               rotation_quat_ff <= csr_wdata[prr_pkg::QUAT_REG_W-1:0];
            end
            prr_pkg::CSR_TRANSLATION_VEC: begin
               translation_vec_ff <= csr_wdata[prr_pkg::VEC_REG_W-1:0];
            end
            prr_pkg::CSR_INTRINSIC_ROW0: begin
               intrinsic_row0_ff <= csr_wdata[prr_pkg::VEC_REG_W-1:0];
            end
            prr_pkg::CSR_INTRINSIC_ROW1: begin
               intrinsic_row1_ff <= csr_wdata[prr_pkg::VEC_REG_W-1:0];
            end
            prr_pkg::CSR_INTRINSIC_ROW2: begin
               intrinsic_row2_ff <= csr_wdata[prr_pkg::VEC_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   prr_transform u_transform (
      .clock           (clock),
      .reset           (reset),
      .rotation_quat   (rotation_quat_ff),
      .translation_vec (translation_vec_ff),
      .intrinsic_row0  (intrinsic_row0_ff),
      .intrinsic_row1  (intrinsic_row1_ff),
      .intrinsic_row2  (intrinsic_row2_ff),
      .req_ch          (req_ch),
      .out_valid       (proj_valid),
      .out_ready       (proj_ready),
      .proj            (proj)
   );

   prr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .in_valid (proj_valid),
      .in_ready (proj_ready),
      .proj     (proj),
      .rsp_ch   (rsp_ch)
   );

endmodule
